[design/rltw_pkg.sv]
package rltw_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_TASKS     = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Field widths
  localparam int ADDR_W = 64;
  localparam int TID_W  = 4;
  localparam int OWN_W  = 5;
  localparam int CNT_W  = 16;
  localparam int MASK_W = 16;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  localparam logic [OWN_W-1:0] NO_OWNER  = 5'd31;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ANN_ACQ   = 3'd0;
  localparam logic [OP_W-1:0] OP_ANN_TRY   = 3'd1;
  localparam logic [OP_W-1:0] OP_ANN_REL   = 3'd2;
  localparam logic [OP_W-1:0] OP_ANN_OTHER = 3'd3;
  localparam logic [OP_W-1:0] OP_COM_ACQ   = 3'd4;
  localparam logic [OP_W-1:0] OP_COM_TRY   = 3'd5;
  localparam logic [OP_W-1:0] OP_COM_REL   = 3'd6;
  localparam logic [OP_W-1:0] OP_ANN_ALT   = 3'd7;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_REL_UNKNOWN = 3'd1;
  localparam logic [ST_W-1:0] ST_REL_NONOWN  = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL        = 3'd3;
  localparam logic [ST_W-1:0] ST_ACQ_HELD    = 3'd4;

  // One lock table entry
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [OWN_W-1:0]  owner;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] waiters;
  } entry_t;

  // Table write command
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  // Waiter bit of a task; tasks beyond MAX_TASKS have none
  function automatic logic [MASK_W-1:0] task_bit(input logic [TID_W-1:0] tid);
    logic [MASK_W-1:0] m;
    m = '0;
    if (int'(tid) < MAX_TASKS) begin
      m = MASK_W'(1) << tid;
    end
    return m;
  endfunction

  // Announce class: ops 0..3 and the unused code seven
  function automatic logic is_announce(input logic [OP_W-1:0] op);
    return (op[2] == 1'b0) || (op == OP_ANN_ALT);
  endfunction

endpackage

[design/rltw_table.sv]
module rltw_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rltw_pkg::IDX_W-1:0]      rd_idx,
  output rltw_pkg::entry_t                rd_ent,
  input  rltw_pkg::tbl_wr_t               wr
);

  logic [rltw_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [rltw_pkg::ADDR_W-1:0]        addr_q   [rltw_pkg::TABLE_ENTRIES];
  logic [rltw_pkg::OWN_W-1:0]         owner_q  [rltw_pkg::TABLE_ENTRIES];
  logic [rltw_pkg::CNT_W-1:0]         count_q  [rltw_pkg::TABLE_ENTRIES];
  logic [rltw_pkg::MASK_W-1:0]        waiter_q [rltw_pkg::TABLE_ENTRIES];

  // Valid bits: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.idx] <= wr.data.valid;
    end
  end

  // Entry payload: only read behind its valid bit
  always_ff @(posedge clk) begin
    if (wr.en) begin
      addr_q[wr.idx]   <= wr.data.address;
      owner_q[wr.idx]  <= wr.data.owner;
      count_q[wr.idx]  <= wr.data.count;
      waiter_q[wr.idx] <= wr.data.waiters;
    end
  end

  // Single read port, walked by the sequencer
  always_comb begin
    rd_ent.valid   = valid_r[rd_idx];
    rd_ent.address = addr_q[rd_idx];
    rd_ent.owner   = owner_q[rd_idx];
    rd_ent.count   = count_q[rd_idx];
    rd_ent.waiters = waiter_q[rd_idx];
  end

endmodule

[design/rltw_ctrl.sv]
module rltw_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             enabled,
  input  logic                             start,
  output logic                             busy,
  input  logic [rltw_pkg::OP_W-1:0]        in_op,
  input  logic [rltw_pkg::TID_W-1:0]       in_task_id,
  input  logic [rltw_pkg::ADDR_W-1:0]      in_address,
  input  logic [rltw_pkg::MASK_W-1:0]      in_candidate_mask,
  input  logic                             in_skip,
  output logic [rltw_pkg::IDX_W-1:0]       rd_idx,
  input  rltw_pkg::entry_t                 rd_ent,
  output rltw_pkg::tbl_wr_t                wr,
  output logic                             out_valid,
  output logic [rltw_pkg::MASK_W-1:0]      out_filtered_mask,
  output logic                             out_self_waits,
  output logic                             out_checkpoint,
  output logic                             out_try_busy,
  output logic [rltw_pkg::ST_W-1:0]        out_status
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;
  localparam logic [1:0] S_FILTER = 2'd3;

  localparam logic [rltw_pkg::IDX_W-1:0] LAST_IDX =
    rltw_pkg::IDX_W'(rltw_pkg::TABLE_ENTRIES - 1);

  logic [1:0]                      state_r, state_nxt;
  logic [rltw_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [rltw_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [rltw_pkg::TID_W-1:0]      tid_r, tid_nxt;
  logic [rltw_pkg::ADDR_W-1:0]     addr_r, addr_nxt;
  logic [rltw_pkg::MASK_W-1:0]     mask_r, mask_nxt;
  logic                            sw_r, sw_nxt;
  logic                            chk_r, chk_nxt;
  logic [rltw_pkg::ST_W-1:0]       stat_r, stat_nxt;
  logic                            hit_r, hit_nxt;
  logic [rltw_pkg::IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                            free_r, free_nxt;
  logic [rltw_pkg::IDX_W-1:0]      free_idx_r, free_idx_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [rltw_pkg::MASK_W-1:0]     out_mask_r, out_mask_nxt;
  logic                            out_sw_r, out_sw_nxt;
  logic                            out_chk_r, out_chk_nxt;
  logic                            out_busy_r, out_busy_nxt;
  logic [rltw_pkg::ST_W-1:0]       out_stat_r, out_stat_nxt;

  logic [rltw_pkg::MASK_W-1:0]     me;
  logic [rltw_pkg::OWN_W-1:0]      tid_own;
  logic                            ann_in;
  logic                            ann_r;

  // Apply-step results
  rltw_pkg::entry_t                ent_a;
  logic [rltw_pkg::ST_W-1:0]       st_a;
  logic                            bz_a;
  logic                            we_a;

  // Filter-step results
  logic                            held;
  logic [rltw_pkg::MASK_W-1:0]     filt_mask;
  logic                            filt_sw;

  assign me      = rltw_pkg::task_bit(tid_r);
  assign tid_own = {1'b0, tid_r};
  assign ann_in  = rltw_pkg::is_announce(in_op);
  assign ann_r   = rltw_pkg::is_announce(op_r);
  assign busy    = (state_r != S_IDLE);

  // Filter: drop waiters of held locks
  assign held      = rd_ent.valid && (rd_ent.owner != rltw_pkg::NO_OWNER);
  assign filt_mask = held ? (mask_r & ~rd_ent.waiters) : mask_r;
  assign filt_sw   = sw_r | (held && ((rd_ent.waiters & me) != '0));

  // Entry update for the selected slot
  always_comb begin
    ent_a = rd_ent;
    st_a  = rltw_pkg::ST_OK;
    bz_a  = 1'b0;
    we_a  = 1'b0;
    if (!hit_r) begin
      ent_a.valid   = 1'b1;
      ent_a.address = addr_r;
      ent_a.owner   = rltw_pkg::NO_OWNER;
      ent_a.count   = '0;
      ent_a.waiters = '0;
    end
    unique case (op_r)
      rltw_pkg::OP_ANN_ACQ: begin
        if (!hit_r && !free_r) begin
          st_a = rltw_pkg::ST_FULL;
        end else begin
          we_a = 1'b1;
          if (ent_a.owner != tid_own) begin
            ent_a.waiters = ent_a.waiters | me;
          end
        end
      end
      rltw_pkg::OP_COM_ACQ, rltw_pkg::OP_COM_TRY: begin
        if (!hit_r && !free_r) begin
          st_a = rltw_pkg::ST_FULL;
        end else begin
          we_a = 1'b1;
          if (ent_a.owner == rltw_pkg::NO_OWNER) begin
            ent_a.owner = tid_own;
            ent_a.count = '0;
            if (op_r == rltw_pkg::OP_COM_ACQ) begin
              ent_a.waiters = ent_a.waiters & ~me;
            end
          end
          if (ent_a.owner == tid_own) begin
            if (ent_a.count != rltw_pkg::COUNT_MAX) begin
              ent_a.count = ent_a.count + 1'b1;
            end
          end else if (op_r == rltw_pkg::OP_COM_ACQ) begin
            st_a = rltw_pkg::ST_ACQ_HELD;
          end else begin
            bz_a = 1'b1;
          end
        end
      end
      rltw_pkg::OP_COM_REL: begin
        if (!hit_r) begin
          st_a = rltw_pkg::ST_REL_UNKNOWN;
        end else begin
          we_a = 1'b1;
          if (ent_a.owner != tid_own) begin
            st_a = rltw_pkg::ST_REL_NONOWN;
          end
          if (ent_a.count != '0) begin
            ent_a.count = ent_a.count - 1'b1;
          end
          if (ent_a.count == '0) begin
            ent_a.owner = rltw_pkg::NO_OWNER;
            if (ent_a.waiters == '0) begin
              ent_a.valid = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    op_nxt       = op_r;
    tid_nxt      = tid_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    sw_nxt       = sw_r;
    chk_nxt      = chk_r;
    stat_nxt     = stat_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    out_valid_nxt = 1'b0;
    out_mask_nxt  = out_mask_r;
    out_sw_nxt    = out_sw_r;
    out_chk_nxt   = out_chk_r;
    out_busy_nxt  = out_busy_r;
    out_stat_nxt  = out_stat_r;
    rd_idx       = idx_r;
    wr           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_op;
          tid_nxt  = in_task_id;
          addr_nxt = in_address;
          mask_nxt = in_candidate_mask;
          sw_nxt   = 1'b0;
          stat_nxt = rltw_pkg::ST_OK;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          idx_nxt  = '0;
          chk_nxt  = ann_in && (in_op <= rltw_pkg::OP_ANN_REL);
          if (ann_in && (in_skip || !enabled)) begin
            // pass-through beat, no table work
            out_valid_nxt = 1'b1;
            out_mask_nxt  = in_candidate_mask;
            out_sw_nxt    = 1'b0;
            out_chk_nxt   = 1'b0;
            out_busy_nxt  = 1'b0;
            out_stat_nxt  = rltw_pkg::ST_OK;
          end else if (!ann_in || (in_op == rltw_pkg::OP_ANN_ACQ)) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_FILTER;
          end
        end
      end
      S_SEARCH: begin
        // lowest matching entry and lowest free slot
        if (rd_ent.valid && (rd_ent.address == addr_r) && !hit_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx_r;
        end
        if (!rd_ent.valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_APPLY;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_APPLY: begin
        rd_idx    = hit_r ? hit_idx_r : free_idx_r;
        wr.en     = we_a;
        wr.idx    = rd_idx;
        wr.data   = ent_a;
        stat_nxt  = st_a;
        idx_nxt   = '0;
        if (ann_r) begin
          state_nxt = S_FILTER;
        end else begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = '0;
          out_sw_nxt    = 1'b0;
          out_chk_nxt   = 1'b0;
          out_busy_nxt  = bz_a;
          out_stat_nxt  = st_a;
          state_nxt     = S_IDLE;
        end
      end
      S_FILTER: begin
        mask_nxt = filt_mask;
        sw_nxt   = filt_sw;
        if (idx_r == LAST_IDX) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = filt_mask;
          out_sw_nxt    = filt_sw;
          out_chk_nxt   = chk_r;
          out_busy_nxt  = 1'b0;
          out_stat_nxt  = stat_r;
          idx_nxt       = '0;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    tid_r      <= tid_nxt;
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    sw_r       <= sw_nxt;
    chk_r      <= chk_nxt;
    stat_r     <= stat_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    out_mask_r <= out_mask_nxt;
    out_sw_r   <= out_sw_nxt;
    out_chk_r  <= out_chk_nxt;
    out_busy_r <= out_busy_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_filtered_mask = out_mask_r;
  assign out_self_waits    = out_sw_r;
  assign out_checkpoint    = out_chk_r;
  assign out_try_busy      = out_busy_r;
  assign out_status        = out_stat_r;

endmodule

[design/recursive_lock_table_waiters_top.sv]
// Recursive mutex lock table with waiter tracking. An event is taken when start
// is high and busy is low; its single result beat appears on the out_ ports for
// exactly one cycle, marked by out_valid, and cannot be held off by the receiver.
// The table has one read port that the sequencer walks one entry per cycle, so
// timing follows the number of table walks: commit ops and announce-acquire
// search the 16 entries and then apply one update; announce-acquire then also
// walks the table again to filter the candidate mask, and other announces walk
// it only for that filter. A skipped announce, or any announce with enabled at
// 0, returns its beat in the next cycle without going busy. The result beat
// shows in the same cycle that busy drops, and a new event may start then.
// The enabled register (reset 1) is written through cfg_valid/cfg_ready, which
// is ready whenever the block is not busy.
module recursive_lock_table_waiters_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [rltw_pkg::OP_W-1:0]        in_op,
  input  logic [rltw_pkg::TID_W-1:0]       in_task_id,
  input  logic [rltw_pkg::ADDR_W-1:0]      in_address,
  input  logic [rltw_pkg::MASK_W-1:0]      in_candidate_mask,
  input  logic                             in_skip,
  output logic                             out_valid,
  output logic [rltw_pkg::MASK_W-1:0]      out_filtered_mask,
  output logic                             out_self_waits,
  output logic                             out_checkpoint,
  output logic                             out_try_busy,
  output logic [rltw_pkg::ST_W-1:0]        out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_enabled
);

  logic                        enabled_r;
  logic [rltw_pkg::IDX_W-1:0]  rd_idx;
  rltw_pkg::entry_t            rd_ent;
  rltw_pkg::tbl_wr_t           wr;

  // Configuration register
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enabled_r <= cfg_enabled;
    end
  end

  rltw_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (rd_idx),
    .rd_ent (rd_ent),
    .wr     (wr)
  );

  rltw_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .enabled           (enabled_r),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_task_id        (in_task_id),
    .in_address        (in_address),
    .in_candidate_mask (in_candidate_mask),
    .in_skip           (in_skip),
    .rd_idx            (rd_idx),
    .rd_ent            (rd_ent),
    .wr                (wr),
    .out_valid         (out_valid),
    .out_filtered_mask (out_filtered_mask),
    .out_self_waits    (out_self_waits),
    .out_checkpoint    (out_checkpoint),
    .out_try_busy      (out_try_busy),
    .out_status        (out_status)
  );

  // Result beats only come out once the sequencer is back to idle
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // A commit op always runs the table walk
  a_commit_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op[2] && (in_op != rltw_pkg::OP_ANN_ALT)) |=> busy)
    else $error("commit op did not start table walk");

  // Announce beats never report a try failure or a release error
  a_chk_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_checkpoint) |->
      (!out_try_busy && (out_status == rltw_pkg::ST_OK || out_status == rltw_pkg::ST_FULL)))
    else $error("announce beat with commit-only fields");

  // A failed try comes from a commit: no mask on that beat
  a_busy_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_try_busy) |-> (out_filtered_mask == '0 && !out_self_waits))
    else $error("try-busy beat carries mask data");

endmodule

[bench/mutex_table_checker_pkg.sv]
package mutex_table_checker_pkg;

  import rltw_pkg::*;

  // Fields of one result beat
  typedef struct packed {
    logic [MASK_W-1:0] filtered_mask;
    logic              self_waits;
    logic              checkpoint;
    logic              try_busy;
    logic [ST_W-1:0]   status;
  } lock_beat_t;

  // Shadow lock table plus the queue of result beats still owed by the block
  class mutex_table_checker;
    bit                enabled;
    bit                ent_valid   [TABLE_ENTRIES];
    logic [ADDR_W-1:0] ent_addr    [TABLE_ENTRIES];
    logic [OWN_W-1:0]  ent_owner   [TABLE_ENTRIES];
    logic [CNT_W-1:0]  ent_count   [TABLE_ENTRIES];
    logic [MASK_W-1:0] ent_waiters [TABLE_ENTRIES];
    lock_beat_t        expected_beats[$];
    lock_beat_t        last_beat;
    int                mismatches;

    function new();
      enabled    = 1'b1;
      mismatches = 0;
      foreach (ent_valid[k]) ent_valid[k] = 1'b0;
    endfunction

    function logic [MASK_W-1:0] waiter_bit(logic [TID_W-1:0] tid);
      if (int'(tid) >= MAX_TASKS) return '0;
      return MASK_W'(1) << tid;
    endfunction

    // Lowest valid entry holding this address, -1 if none
    function int find_lock(logic [ADDR_W-1:0] addr);
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (ent_valid[k] && ent_addr[k] == addr) return k;
      end
      return -1;
    endfunction

    // Existing entry, else the lowest free slot; -1 when the table is full
    function int claim_lock(logic [ADDR_W-1:0] addr);
      int i;
      i = find_lock(addr);
      if (i >= 0) return i;
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (!ent_valid[k]) begin
          ent_valid[k]   = 1'b1;
          ent_addr[k]    = addr;
          ent_owner[k]   = NO_OWNER;
          ent_count[k]   = '0;
          ent_waiters[k] = '0;
          return k;
        end
      end
      return -1;
    endfunction

    // Apply one accepted event to the shadow table and queue its beat
    function void predict_event(logic [OP_W-1:0] op, logic [TID_W-1:0] tid,
                                logic [ADDR_W-1:0] addr, logic [MASK_W-1:0] cand,
                                logic skip);
      lock_beat_t        r;
      logic [MASK_W-1:0] me;
      logic [OWN_W-1:0]  who;
      int                i;
      r   = '0;
      me  = waiter_bit(tid);
      who = OWN_W'(tid);
      if (op[2] == 1'b0 || op == OP_ANN_ALT) begin
        r.filtered_mask = cand;
        if (!skip && enabled) begin
          if (op == OP_ANN_ACQ) begin
            i = claim_lock(addr);
            if (i < 0) r.status = ST_FULL;
            else if (ent_owner[i] != who) ent_waiters[i] |= me;
          end
          r.checkpoint = (op == OP_ANN_ACQ || op == OP_ANN_TRY || op == OP_ANN_REL);
          // drop waiters of every held lock from the candidates
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (ent_valid[k] && ent_owner[k] != NO_OWNER) begin
              r.filtered_mask &= ~ent_waiters[k];
              if ((ent_waiters[k] & me) != '0) r.self_waits = 1'b1;
            end
          end
        end
      end else if (op == OP_COM_ACQ || op == OP_COM_TRY) begin
        i = claim_lock(addr);
        if (i < 0) begin
          r.status = ST_FULL;
        end else begin
          if (ent_owner[i] == NO_OWNER) begin
            ent_owner[i] = who;
            ent_count[i] = '0;
            if (op == OP_COM_ACQ) ent_waiters[i] &= ~me;
          end
          if (ent_owner[i] == who) begin
            if (ent_count[i] != COUNT_MAX) ent_count[i]++;
          end else if (op == OP_COM_ACQ) begin
            r.status = ST_ACQ_HELD;
          end else begin
            r.try_busy = 1'b1;
          end
        end
      end else begin
        i = find_lock(addr);
        if (i < 0) begin
          r.status = ST_REL_UNKNOWN;
        end else begin
          // a non-owner release is flagged but still counts down
          if (ent_owner[i] != who) r.status = ST_REL_NONOWN;
          if (ent_count[i] != '0) ent_count[i]--;
          if (ent_count[i] == '0) begin
            ent_owner[i] = NO_OWNER;
            if (ent_waiters[i] == '0) ent_valid[i] = 1'b0;
          end
        end
      end
      last_beat = r;
      expected_beats.push_back(r);
    endfunction

    function void check_beat(lock_beat_t got);
      lock_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat mask=%h self_waits=%b chk=%b busy=%b st=%0d",
                   $time, got.filtered_mask, got.self_waits, got.checkpoint, got.try_busy,
                   got.status);
        return;
      end
      want = expected_beats.pop_front();
      if (got.filtered_mask !== want.filtered_mask || got.self_waits !== want.self_waits ||
          got.checkpoint !== want.checkpoint || got.try_busy !== want.try_busy ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: beat differs, expected mask=%h self_waits=%b chk=%b busy=%b st=%0d",
                   $time, want.filtered_mask, want.self_waits, want.checkpoint,
                   want.try_busy, want.status);
          $display("%0t:                    got mask=%h self_waits=%b chk=%b busy=%b st=%0d",
                   $time, got.filtered_mask, got.self_waits, got.checkpoint, got.try_busy,
                   got.status);
        end
      end
    endfunction

    function int failures();
      return mismatches + expected_beats.size();
    endfunction
  endclass

endpackage

[bench/testbench.sv]
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import rltw_pkg::*;
  import mutex_table_checker_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 20;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   in_op;
  logic [TID_W-1:0]  in_task_id;
  logic [ADDR_W-1:0] in_address;
  logic [MASK_W-1:0] in_candidate_mask;
  logic              in_skip;
  logic              out_valid;
  logic [MASK_W-1:0] out_filtered_mask;
  logic              out_self_waits;
  logic              out_checkpoint;
  logic              out_try_busy;
  logic [ST_W-1:0]   out_status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_enabled;

  mutex_table_checker sb;
  logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
  int                 idle_pct;
  int                 sent_items;
  int                 stall_cycles = 0;
  int                 idle_plan [3] = '{33, 79, 0};

  always #(CLK_PERIOD / 2) clk = ~clk;

  recursive_lock_table_waiters_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_task_id        (in_task_id),
    .in_address        (in_address),
    .in_candidate_mask (in_candidate_mask),
    .in_skip           (in_skip),
    .out_valid         (out_valid),
    .out_filtered_mask (out_filtered_mask),
    .out_self_waits    (out_self_waits),
    .out_checkpoint    (out_checkpoint),
    .out_try_busy      (out_try_busy),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_enabled       (cfg_enabled)
  );

  // Monitor: check the result beat first, then note a newly accepted event
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_beat('{out_filtered_mask, out_self_waits, out_checkpoint, out_try_busy,
                        out_status});
      if (start && !busy)
        sb.predict_event(in_op, in_task_id, in_address, in_candidate_mask, in_skip);
      if (cfg_valid && cfg_ready) sb.enabled = cfg_enabled;
    end
    if (rst_n && ((start && !busy) || out_valid || (cfg_valid && cfg_ready)))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Watchdog on cycles without any beat moving
  initial begin
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("recursive_lock_table_waiters_top: mismatch");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] any_addr();
    if ($urandom_range(0, 1) == 0) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [MASK_W-1:0] any_mask();
    return MASK_W'($urandom_range(0, 65535));
  endfunction

  // One event beat; returns at the falling edge after it was taken, or after an idle gap drawn from idle_pct
  task automatic send_event(logic [OP_W-1:0] op, logic [TID_W-1:0] tid,
                            logic [ADDR_W-1:0] addr, logic [MASK_W-1:0] cand,
                            logic skip);
    start             <= 1'b1;
    in_op             <= op;
    in_task_id        <= tid;
    in_address        <= addr;
    in_candidate_mask <= cand;
    in_skip           <= skip;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent_items++;
    if ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  endtask

  task automatic pause_until_drained();
    start <= 1'b0;
    @(negedge clk);
    while (sb.expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic write_enable(logic value);
    pause_until_drained();
    cfg_valid   <= 1'b1;
    cfg_enabled <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Announce, take (maybe recursively), release; sometimes with a contender
  task automatic lock_sequence();
    logic [TID_W-1:0]  t;
    logic [TID_W-1:0]  t2;
    logic [ADDR_W-1:0] a;
    bit                contend;
    int                held;
    t       = TID_W'($urandom_range(0, 15));
    t2      = TID_W'($urandom_range(0, 15));
    a       = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    contend = ($urandom_range(0, 2) == 0);
    held    = 0;
    if ($urandom_range(0, 3) != 0) send_event(OP_ANN_ACQ, t, a, any_mask(), 1'b0);
    if (contend) send_event(OP_ANN_ACQ, t2, a, any_mask(), 1'b0);
    repeat ($urandom_range(1, 3)) begin
      send_event($urandom_range(0, 1) ? OP_COM_ACQ : OP_COM_TRY, t, a, any_mask(),
                 1'($urandom_range(0, 1)));
      if (sb.last_beat.status == ST_OK && !sb.last_beat.try_busy) held++;
    end
    if (contend) begin
      send_event(OP_COM_ACQ, t2, a, any_mask(), 1'b0);
      send_event(OP_COM_TRY, t2, a, any_mask(), 1'b0);
    end
    send_event($urandom_range(0, 1) ? OP_ANN_OTHER : OP_ANN_TRY,
               TID_W'($urandom_range(0, 15)), any_addr(), any_mask(),
               1'($urandom_range(0, 9) == 0));
    send_event(OP_ANN_REL, t, a, any_mask(), 1'b0);
    repeat (held) send_event(OP_COM_REL, t, a, any_mask(), 1'($urandom_range(0, 1)));
    if (contend) begin
      send_event(OP_COM_ACQ, t2, a, any_mask(), 1'b0);
      if (sb.last_beat.status == ST_OK) send_event(OP_COM_REL, t2, a, any_mask(), 1'b0);
    end
  endtask

  // Empty the table: owners release, then each waiter takes and drops the lock
  task automatic release_all();
    logic [ADDR_W-1:0] a;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (sb.ent_valid[k]) begin
        a = sb.ent_addr[k];
        while (sb.ent_valid[k] && sb.ent_addr[k] == a && sb.ent_owner[k] != NO_OWNER)
          send_event(OP_COM_REL, sb.ent_owner[k][TID_W-1:0], a, any_mask(), 1'b0);
        for (int t = 0; t < MAX_TASKS; t++) begin
          if (sb.ent_valid[k] && sb.ent_addr[k] == a && sb.ent_waiters[k][t]) begin
            send_event(OP_COM_ACQ, TID_W'(t), a, any_mask(), 1'b0);
            send_event(OP_COM_REL, TID_W'(t), a, any_mask(), 1'b0);
          end
        end
      end
    end
  endtask

  task automatic run_random(int n);
    int goal;
    int pick;
    goal = sent_items + n;
    while (sent_items < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        lock_sequence();
      end else if (pick < 85) begin
        send_event(OP_W'($urandom_range(0, 7)), TID_W'($urandom_range(0, 15)), any_addr(),
                   any_mask(), 1'($urandom_range(0, 3) == 0));
      end else if (pick < 90) begin
        // crowd the table past its size so that it fills up
        for (int j = 0; j <= TABLE_ENTRIES; j++)
          send_event(OP_ANN_ACQ, TID_W'($urandom_range(0, 15)), addr_pool[j], any_mask(),
                     1'b0);
      end else if (pick < 97) begin
        release_all();
      end else begin
        pause_until_drained();
      end
    end
  endtask

  initial begin
    sb = new();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = 64'h8000_0000_0000_0000;
    for (int j = 3; j < POOL_SIZE; j++) addr_pool[j] = {$urandom(), $urandom()};
    rst_n             = 1'b0;
    start             = 1'b0;
    in_op             = OP_ANN_OTHER;
    in_task_id        = '0;
    in_address        = '0;
    in_candidate_mask = '0;
    in_skip           = 1'b0;
    cfg_valid         = 1'b0;
    cfg_enabled       = 1'b1;
    idle_pct          = 0;
    sent_items        = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    write_enable(1'b1);

    // directed: ownership, contention, recursion and release corner cases
    send_event(OP_COM_REL,   4'd0,  '0, 16'h0000, 1'b0);  // release of unknown lock
    send_event(OP_ANN_ACQ,   4'd15, '1, 16'hFFFF, 1'b0);
    send_event(OP_COM_ACQ,   4'd3,  '1, 16'h1234, 1'b1);
    send_event(OP_ANN_OTHER, 4'd15, '1, 16'hFFFF, 1'b0);  // self waits, no checkpoint
    send_event(OP_ANN_ALT,   4'd15, '0, 16'hFFFF, 1'b0);  // spare code acts as other
    send_event(OP_ANN_TRY,   4'd0,  '1, 16'h0000, 1'b0);
    send_event(OP_COM_ACQ,   4'd15, '1, 16'h0000, 1'b0);  // acquire while held
    send_event(OP_COM_TRY,   4'd15, '1, 16'h0000, 1'b0);  // try on busy lock
    send_event(OP_COM_TRY,   4'd3,  '1, 16'h0000, 1'b0);  // recursive take
    send_event(OP_ANN_ACQ,   4'd3,  '1, 16'hFFFF, 1'b0);  // owner is not a waiter
    send_event(OP_COM_REL,   4'd15, '1, 16'h0000, 1'b0);  // release by non-owner
    send_event(OP_ANN_REL,   4'd3,  '1, 16'h5A5A, 1'b1);  // skipped announce
    send_event(OP_COM_REL,   4'd3,  '1, 16'h0000, 1'b0);  // free, waiter keeps entry
    send_event(OP_COM_REL,   4'd3,  '1, 16'h0000, 1'b0);  // release at count zero
    send_event(OP_COM_ACQ,   4'd15, '1, 16'h0000, 1'b0);
    send_event(OP_COM_REL,   4'd15, '1, 16'h0000, 1'b0);  // entry freed
    send_event(OP_ANN_ACQ,   4'd0,  '0, 16'hFFFF, 1'b0);
    send_event(OP_ANN_ACQ,   4'd0,  '0, 16'hFFFF, 1'b0);  // already waiting
    write_enable(1'b0);
    send_event(OP_ANN_ACQ,   4'd9,  '0, 16'hA5A5, 1'b0);  // disabled: mask passes
    send_event(OP_ANN_OTHER, 4'd0,  '0, 16'h8000, 1'b0);
    send_event(OP_COM_ACQ,   4'd0,  '0, 16'h0000, 1'b0);  // commits still act
    send_event(OP_COM_REL,   4'd0,  '0, 16'h0000, 1'b0);
    write_enable(1'b1);

    // random phases with different sender idling, each with a disabled stretch
    foreach (idle_plan[p]) begin
      idle_pct = idle_plan[p];
      run_random(380);
      write_enable(1'b0);
      run_random(70);
      write_enable(1'b1);
      run_random(100);
    end

    pause_until_drained();
    repeat (40) @(negedge clk);
    if (sb.failures() == 0)
      $display("recursive_lock_table_waiters_top: match");
    else
      $display("recursive_lock_table_waiters_top: mismatch");
    $finish;
  end

endmodule
